// ===== rtl/rcc_pkg.sv =====
// Package for the small-modulus RSA/CRT cipher.
// Holds the item structs, controller states, datapath commands and operand selects.
// No dependencies.
package rcc_pkg;

  localparam int unsigned PrimeW = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned DivW   = 32;
  localparam int unsigned CoefW  = 10;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegPrimeP  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPrimeQ  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegModulus = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPubExp  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPrivExp = 3'd4;

  localparam logic OpEncrypt = 1'b0;

  typedef struct packed {
    logic             opcode;
    logic [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             range_error;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SET_MN, CMD_SET_MP1, CMD_SET_MQ1, CMD_SET_MP,
    CMD_SET_MQ, CMD_E_REM, CMD_R_REM, CMD_B_REM, CMD_BSQ_REM, CMD_M1,
    CMD_M2, CMD_EU_INIT, CMD_ENR_REM, CMD_EU_STEP, CMD_QINV, CMD_TMP_REM,
    CMD_RES_RANGE, CMD_RES_ZERO, CMD_RES_R, CMD_RES_CRT, CMD_PUSH
  } cmd_e;

  typedef enum logic [3:0] {
    DS_ONE, DS_VAL, DS_RB, DS_BB, DS_DEXP, DS_QP, DS_EU, DS_M2, DS_DIFF, DS_H
  } div_src_e;

  typedef enum logic [1:0] {
    PH_ENC, PH_M1, PH_M2
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DP, S_DP_W, S_M1SET, S_MP_INIT, S_MP_W1, S_MP_B, S_MP_W2,
    S_MP_LOOP, S_MP_W3, S_MP_SQ, S_MP_W4, S_DQ, S_DQ_D, S_DQ_W, S_M2SET,
    S_EU1, S_EU2, S_EU3, S_EU_LOOP, S_EU_W, S_D0, S_D0W, S_D1, S_D1W, S_D2,
    S_D2W, S_OUT
  } state_e;

  typedef struct packed {
    cmd_e     cmd;
    logic     div_start;
    div_src_e div_src;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic e_zero;
    logic e_lsb;
    logic enr_zero;
    logic range_err;
    logic op;
    logic p_small;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/rsa_crt_cipher.sv =====
// RSA cipher with small primes: encrypt by square-and-multiply, decrypt by CRT.
// Depends on rcc_pkg, rcc_ctrl, rcc_dpath (which holds rcc_div).
//
// Input channel (in_valid_i/in_stall_o/in_item_i) takes one item: opcode and value.
// Output channel (out_valid_o/out_stall_i/out_item_o) gives one result per item.
// Key registers are written through cfg_we_i/cfg_idx_i/cfg_data_i only while idle, a rule for the
// user that the block does not enforce: 0 prime_p, 1 prime_q, 2 modulus_n, 3 public_exp, 4 private_exp.
// One item is worked at a time. Every modular product and every remainder goes
// through a single restoring divider. Encryption uses two setup divides, then one
// square per bit of e and one multiply per set bit of e.
// Decryption runs two half-size exponentiations, the Euclid inverse (one divide
// per step) and three more divides.
// A value not below modulus_n returns result 0 with range_error.
// A finished result sits in the output register; the next item is accepted
// meanwhile and its result waits in the datapath while the receiver stalls.
// Reset loads the key registers with 3, 5, 15, 3, 3 and empties the block.
module rsa_crt_cipher import rcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  ctl_t ctl;
  sts_t sts;

  rcc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .ctl_o (ctl)
  );

  rcc_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_item_i,
    .out_stall_i,
    .out_valid_o,
    .out_item_o,
    .ctl_i (ctl),
    .sts_o (sts)
  );

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.cmd == CMD_PUSH |-> !(out_valid_o && out_stall_i))
    else $error("push over a waiting item");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.range_error |-> out_item_o.result == '0)
    else $error("range error with nonzero result");

endmodule

// ===== rtl/rcc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rcc_pkg for widths.
module rcc_div import rcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivW-1:0]  quo_o,
  output logic [WordW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [WordW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [WordW:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], ge};
      rem_d = ge ? WordW'(trial - {1'b0, dvs_q}) : trial[WordW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/rcc_dpath.sv =====
// Datapath: key registers, working registers, shared divider and output register.
// Depends on rcc_pkg and rcc_div.
module rcc_dpath import rcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  in_item_t           in_item_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output out_item_t          out_item_o,
  input  ctl_t               ctl_i,
  output sts_t               sts_o
);

  logic [PrimeW-1:0] p_q, q_q;
  logic [WordW-1:0]  n_q, pub_q, priv_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              op_q, op_d, rng_q, rng_d;
  logic [WordW-1:0]  val_q, val_d, m_q, m_d, e_q, e_d, r_q, r_d, b_q, b_d;
  logic [WordW-1:0]  res_q, res_d;
  logic [PrimeW-1:0] m1_q, m1_d, m2_q, m2_d, er_q, er_d, enr_q, enr_d;
  logic [PrimeW-1:0] qinv_q, qinv_d, tmp_q, tmp_d;
  logic signed [CoefW-1:0] t_q, t_d, nt_q, nt_d;

  logic [DivW-1:0]   dividend, quo;
  logic [WordW-1:0]  divisor, rem;
  logic              div_done;
  logic [PrimeW:0]   diff;
  logic signed [CoefW+PrimeW:0] qt_nt;
  logic [CoefW-1:0]  t_pos;

  assign diff  = {1'b0, m1_q} + {1'b0, p_q} - {1'b0, tmp_q};
  assign qt_nt = $signed({1'b0, quo[PrimeW-1:0]}) * nt_q;
  assign t_pos = t_q[CoefW-1] ? CoefW'(t_q + $signed({2'b0, p_q})) : t_q;

  always_comb begin
    case (ctl_i.div_src)
      DS_ONE:  dividend = DivW'(1);
      DS_VAL:  dividend = DivW'(val_q);
      DS_RB:   dividend = r_q * b_q;
      DS_BB:   dividend = b_q * b_q;
      DS_DEXP: dividend = DivW'(priv_q);
      DS_QP:   dividend = DivW'(q_q);
      DS_EU:   dividend = DivW'(er_q);
      DS_M2:   dividend = DivW'(m2_q);
      DS_DIFF: dividend = DivW'(diff);
      DS_H:    dividend = DivW'(WordW'(qinv_q) * WordW'(tmp_q));
      default: dividend = '0;
    endcase
    divisor = (ctl_i.div_src == DS_EU) ? WordW'(enr_q) : m_q;
  end

  rcc_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (ctl_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_comb begin
    op_d = op_q; rng_d = rng_q; val_d = val_q; m_d = m_q; e_d = e_q;
    r_d = r_q; b_d = b_q; res_d = res_q; m1_d = m1_q; m2_d = m2_q;
    er_d = er_q; enr_d = enr_q; qinv_d = qinv_q; tmp_d = tmp_q;
    t_d = t_q; nt_d = nt_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (ctl_i.cmd)
      CMD_LOAD: begin
        op_d  = in_item_i.opcode;
        val_d = in_item_i.value;
        rng_d = in_item_i.value >= n_q;
      end
      CMD_SET_MN:  begin
        m_d = n_q;
        e_d = pub_q;
      end
      CMD_SET_MP1: m_d = WordW'(p_q - 1'b1);
      CMD_SET_MQ1: m_d = WordW'(q_q - 1'b1);
      CMD_SET_MP:  m_d = WordW'(p_q);
      CMD_SET_MQ:  m_d = WordW'(q_q);
      CMD_E_REM:   e_d = rem;
      CMD_R_REM:   r_d = rem;
      CMD_B_REM:   b_d = rem;
      CMD_BSQ_REM: begin
        b_d = rem;
        e_d = e_q >> 1;
      end
      CMD_M1:      m1_d = r_q[PrimeW-1:0];
      CMD_M2:      m2_d = r_q[PrimeW-1:0];
      CMD_EU_INIT: begin
        m_d  = WordW'(p_q);
        er_d = p_q;
        t_d  = '0;
        nt_d = CoefW'(1);
      end
      CMD_ENR_REM: enr_d = rem[PrimeW-1:0];
      CMD_EU_STEP: begin
        t_d   = nt_q;
        nt_d  = CoefW'(t_q - qt_nt);
        er_d  = enr_q;
        enr_d = rem[PrimeW-1:0];
      end
      CMD_QINV:      qinv_d = (er_q == PrimeW'(1)) ? t_pos[PrimeW-1:0] : '0;
      CMD_TMP_REM:   tmp_d = rem[PrimeW-1:0];
      CMD_RES_RANGE: res_d = '0;
      CMD_RES_ZERO:  res_d = '0;
      CMD_RES_R:     res_d = r_q;
      CMD_RES_CRT:   res_d = WordW'(m2_q) + rem[PrimeW-1:0] * q_q;
      CMD_PUSH: begin
        out_valid_d       = 1'b1;
        out_d.result      = res_q;
        out_d.range_error = rng_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= PrimeW'(3);
      q_q         <= PrimeW'(5);
      n_q         <= WordW'(15);
      pub_q       <= WordW'(3);
      priv_q      <= WordW'(3);
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPrimeP:  p_q    <= cfg_data_i[PrimeW-1:0];
          RegPrimeQ:  q_q    <= cfg_data_i[PrimeW-1:0];
          RegModulus: n_q    <= cfg_data_i;
          RegPubExp:  pub_q  <= cfg_data_i;
          RegPrivExp: priv_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; rng_q <= rng_d; val_q <= val_d; m_q <= m_d; e_q <= e_d;
    r_q <= r_d; b_q <= b_d; res_q <= res_d; m1_q <= m1_d; m2_q <= m2_d;
    er_q <= er_d; enr_q <= enr_d; qinv_q <= qinv_d; tmp_q <= tmp_d;
    t_q <= t_d; nt_q <= nt_d; out_q <= out_d;
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.e_zero    = e_q == '0;
  assign sts_o.e_lsb     = e_q[0];
  assign sts_o.enr_zero  = enr_q == '0;
  assign sts_o.range_err = rng_q;
  assign sts_o.op        = op_q;
  assign sts_o.p_small   = (p_q < PrimeW'(2)) || (q_q < PrimeW'(2));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/rcc_ctrl.sv =====
// Controller: sequences modular exponentiation, inverse search and CRT recombination.
// Depends on rcc_pkg.
module rcc_ctrl import rcc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CHK;
      S_CHK: begin
        if (sts_i.range_err) state_d = S_OUT;
        else if (sts_i.op == OpEncrypt) begin
          state_d = S_MP_INIT;
          ph_d    = PH_ENC;
        end else if (sts_i.p_small) state_d = S_OUT;
        else state_d = S_DP;
      end
      S_DP:    state_d = S_DP_W;
      S_DP_W:  if (sts_i.div_done) state_d = S_M1SET;
      S_M1SET: begin
        state_d = S_MP_INIT;
        ph_d    = PH_M1;
      end
      S_MP_INIT: state_d = S_MP_W1;
      S_MP_W1:   if (sts_i.div_done) state_d = S_MP_B;
      S_MP_B:    state_d = S_MP_W2;
      S_MP_W2:   if (sts_i.div_done) state_d = S_MP_LOOP;
      S_MP_LOOP: begin
        if (sts_i.e_zero) begin
          case (ph_q)
            PH_ENC:  state_d = S_OUT;
            PH_M1:   state_d = S_DQ;
            default: state_d = S_EU1;
          endcase
        end else if (sts_i.e_lsb) state_d = S_MP_W3;
        else state_d = S_MP_SQ;
      end
      S_MP_W3: if (sts_i.div_done) state_d = S_MP_SQ;
      S_MP_SQ: state_d = S_MP_W4;
      S_MP_W4: if (sts_i.div_done) state_d = S_MP_LOOP;
      S_DQ:    state_d = S_DQ_D;
      S_DQ_D:  state_d = S_DQ_W;
      S_DQ_W:  if (sts_i.div_done) state_d = S_M2SET;
      S_M2SET: begin
        state_d = S_MP_INIT;
        ph_d    = PH_M2;
      end
      S_EU1: state_d = S_EU2;
      S_EU2: state_d = S_EU3;
      S_EU3: if (sts_i.div_done) state_d = S_EU_LOOP;
      S_EU_LOOP: state_d = sts_i.enr_zero ? S_D0 : S_EU_W;
      S_EU_W: if (sts_i.div_done) state_d = S_EU_LOOP;
      S_D0:  state_d = S_D0W;
      S_D0W: if (sts_i.div_done) state_d = S_D1;
      S_D1:  state_d = S_D1W;
      S_D1W: if (sts_i.div_done) state_d = S_D2;
      S_D2:  state_d = S_D2W;
      S_D2W: if (sts_i.div_done) state_d = S_OUT;
      S_OUT: if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.cmd       = CMD_NONE;
    ctl_o.div_start = 1'b0;
    ctl_o.div_src   = DS_ONE;
    in_stall_o      = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) ctl_o.cmd = CMD_LOAD;
      end
      S_CHK: begin
        if (sts_i.range_err) ctl_o.cmd = CMD_RES_RANGE;
        else if (sts_i.op == OpEncrypt) ctl_o.cmd = CMD_SET_MN;
        else if (sts_i.p_small) ctl_o.cmd = CMD_RES_ZERO;
        else ctl_o.cmd = CMD_SET_MP1;
      end
      S_DP: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_DEXP;
      end
      S_DP_W:  if (sts_i.div_done) ctl_o.cmd = CMD_E_REM;
      S_M1SET: ctl_o.cmd = CMD_SET_MP;
      S_MP_INIT: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_ONE;
      end
      S_MP_W1: if (sts_i.div_done) ctl_o.cmd = CMD_R_REM;
      S_MP_B: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_VAL;
      end
      S_MP_W2: if (sts_i.div_done) ctl_o.cmd = CMD_B_REM;
      S_MP_LOOP: begin
        if (sts_i.e_zero) begin
          case (ph_q)
            PH_ENC:  ctl_o.cmd = CMD_RES_R;
            PH_M1:   ctl_o.cmd = CMD_M1;
            default: ctl_o.cmd = CMD_M2;
          endcase
        end else if (sts_i.e_lsb) begin
          ctl_o.div_start = 1'b1;
          ctl_o.div_src   = DS_RB;
        end
      end
      S_MP_W3: if (sts_i.div_done) ctl_o.cmd = CMD_R_REM;
      S_MP_SQ: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_BB;
      end
      S_MP_W4: if (sts_i.div_done) ctl_o.cmd = CMD_BSQ_REM;
      S_DQ:    ctl_o.cmd = CMD_SET_MQ1;
      S_DQ_D: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_DEXP;
      end
      S_DQ_W:  if (sts_i.div_done) ctl_o.cmd = CMD_E_REM;
      S_M2SET: ctl_o.cmd = CMD_SET_MQ;
      S_EU1:   ctl_o.cmd = CMD_EU_INIT;
      S_EU2: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_QP;
      end
      S_EU3: if (sts_i.div_done) ctl_o.cmd = CMD_ENR_REM;
      S_EU_LOOP: begin
        if (sts_i.enr_zero) ctl_o.cmd = CMD_QINV;
        else begin
          ctl_o.div_start = 1'b1;
          ctl_o.div_src   = DS_EU;
        end
      end
      S_EU_W: if (sts_i.div_done) ctl_o.cmd = CMD_EU_STEP;
      S_D0: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_M2;
      end
      S_D0W: if (sts_i.div_done) ctl_o.cmd = CMD_TMP_REM;
      S_D1: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_DIFF;
      end
      S_D1W: if (sts_i.div_done) ctl_o.cmd = CMD_TMP_REM;
      S_D2: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_src   = DS_H;
      end
      S_D2W: if (sts_i.div_done) ctl_o.cmd = CMD_RES_CRT;
      S_OUT: if (!sts_i.out_busy) ctl_o.cmd = CMD_PUSH;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_ENC;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for rsa_crt_cipher: directed table, edge-case keys, then random items.
// Predicts each result in SystemVerilog and compares it with the output item.
// Depends on rcc_pkg and the rsa_crt_cipher RTL.
module tb_top;
  import rcc_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;

  rsa_crt_cipher dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  typedef struct packed {
    logic             opcode;
    logic [WordW-1:0] value;
    logic             known;
    logic [WordW-1:0] result;
    logic             range_error;
  } vec_t;

  logic [PrimeW-1:0] key_p, key_q;
  logic [WordW-1:0]  key_n, key_e, key_d;
  out_item_t         pending_results[$];
  int unsigned       mismatches, cycles, accepted, checked, long_hold;
  bit                hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles > 10000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned ex,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (ex != 0) begin
      if (ex[0]) r = (r * b) % m;
      b = (b * b) % m;
      ex = ex >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned m);
    longint t, nt, tmp_t;
    longint unsigned r, nr, qt, tmp_r;
    t = 0; nt = 1; r = m; nr = a % m;
    while (nr != 0) begin
      qt = r / nr;
      tmp_t = t - longint'(qt) * nt;
      tmp_r = r - qt * nr;
      t = nt; nt = tmp_t; r = nr; nr = tmp_r;
    end
    if (r != 1) return 0;
    if (t < 0) t += longint'(m);
    return $unsigned(t);
  endfunction

  function automatic out_item_t cipher_result(in_item_t it);
    out_item_t o;
    longint unsigned p, q, m1, m2, qi, diff, h, res;
    o = '0;
    if (it.value >= key_n) begin
      o.range_error = 1'b1;
      return o;
    end
    if (it.opcode == OpEncrypt) begin
      res = pow_mod(it.value, key_e, key_n);
    end else begin
      p = key_p; q = key_q;
      if (p < 2 || q < 2) begin
        res = 0;
      end else begin
        m1 = pow_mod(it.value, key_d % (p - 1), p);
        m2 = pow_mod(it.value, key_d % (q - 1), q);
        qi = inv_mod(q, p);
        diff = (m1 + p - (m2 % p)) % p;
        h = (qi * diff) % p;
        res = m2 + h * q;
      end
    end
    o.result = res[WordW-1:0];
    return o;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      RegPrimeP:  key_p = data[PrimeW-1:0];
      RegPrimeQ:  key_q = data[PrimeW-1:0];
      RegModulus: key_n = data;
      RegPubExp:  key_e = data;
      RegPrivExp: key_d = data;
      default: ;
    endcase
  endtask

  task automatic set_key(int p, int q, int n, int e, int d);
    write_reg(RegPrimeP, WordW'(p));
    write_reg(RegPrimeQ, WordW'(q));
    write_reg(RegModulus, WordW'(n));
    write_reg(RegPubExp, WordW'(e));
    write_reg(RegPrivExp, WordW'(d));
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // Hold valid until the item is accepted; the expected entry goes in when accepted.
  task automatic send_item(in_item_t it, out_item_t expd);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(expd);
    accepted++;
  endtask

  task automatic send_random(int count, int max_val);
    in_item_t it;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        it.opcode = 1'($urandom_range(0, 1));
        it.value  = ($urandom_range(0, 15) == 0) ? WordW'($urandom)
                                                 : WordW'($urandom_range(0, max_val));
        send_item(it, cipher_result(it));
        burst--; count--;
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t expd;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", out_item);
      end else begin
        expd = pending_results.pop_front();
        checked++;
        if (out_item.result !== expd.result || out_item.range_error !== expd.range_error)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("item %0d: expected %h/%b, got %h/%b", checked, expd.result,
                     expd.range_error, out_item.result, out_item.range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      case (cycles[10:9])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (long_hold != 0);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (6000) @(posedge clk);
    hold_off = 1'b0;
  end

  vec_t dir_tab[] = '{
    '{1'b0, 16'd0,     1'b1, 16'd0, 1'b0},
    '{1'b0, 16'd2,     1'b1, 16'd8, 1'b0},
    '{1'b0, 16'd14,    1'b0, 16'd0, 1'b0},
    '{1'b1, 16'd8,     1'b0, 16'd0, 1'b0},
    '{1'b1, 16'd0,     1'b0, 16'd0, 1'b0},
    '{1'b1, 16'd14,    1'b0, 16'd0, 1'b0},
    '{1'b0, 16'd15,    1'b1, 16'd0, 1'b1},
    '{1'b1, 16'd15,    1'b1, 16'd0, 1'b1},
    '{1'b0, 16'hffff,  1'b1, 16'd0, 1'b1},
    '{1'b1, 16'hffff,  1'b1, 16'd0, 1'b1},
    '{1'b1, 16'd7,     1'b0, 16'd0, 1'b0},
    '{1'b0, 16'd1,     1'b1, 16'd1, 1'b0}
  };

  initial begin
    in_item_t it;
    out_item_t expd;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0; in_item = '0;
    cycles = 0; mismatches = 0; accepted = 0; checked = 0; long_hold = 0;
    key_p = 8'd3; key_q = 8'd5; key_n = 16'd15; key_e = 16'd3; key_d = 16'd3;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      it.opcode = dir_tab[i].opcode;
      it.value  = dir_tab[i].value;
      expd = cipher_result(it);
      if (dir_tab[i].known) begin
        expd.result = dir_tab[i].result;
        expd.range_error = dir_tab[i].range_error;
      end
      send_item(it, expd);
    end
    in_valid <= 1'b0;
    drain_results();

    // Exponent zero, modulus one, equal primes, degenerate primes, modulus zero, wide CRT sum.
    set_key(13, 13, 1, 0, 0);
    it = '{1'b0, 16'd0}; send_item(it, cipher_result(it));
    it = '{1'b1, 16'd0}; send_item(it, cipher_result(it));
    it = '{1'b0, 16'd1}; send_item(it, cipher_result(it));
    in_valid <= 1'b0;
    drain_results();
    set_key(1, 0, 65535, 65535, 65535);
    it = '{1'b1, 16'd65534}; send_item(it, cipher_result(it));
    it = '{1'b0, 16'd65534}; send_item(it, cipher_result(it));
    in_valid <= 1'b0;
    drain_results();
    set_key(255, 251, 0, 1, 65535);
    it = '{1'b0, 16'd0}; send_item(it, cipher_result(it));
    in_valid <= 1'b0;
    drain_results();
    set_key(251, 255, 64005, 17, 257);
    it = '{1'b1, 16'd64004}; send_item(it, cipher_result(it));
    it = '{1'b1, 16'd12345}; send_item(it, cipher_result(it));
    in_valid <= 1'b0;
    drain_results();

    set_key(61, 53, 3233, 17, 2753);
    long_hold = 1;
    send_random(150, 3300);
    drain_results();
    set_key(11, 13, 143, 7, 103);
    send_random(140, 160);
    drain_results();
    set_key(3, 5, 15, 3, 3);
    send_random(80, 20);
    drain_results();
    set_key(251, 241, 60491, 65535, 65535);
    send_random(60, 65535);
    drain_results();
    set_key(7, 2, 14, 0, 1);
    send_random(80, 20);
    drain_results();
    set_key(17, 17, 289, 5, 11);
    send_random(70, 300);
    drain_results();

    $display("Covered %0d items over the reset key and ten written keys, %0d results checked.",
             accepted, checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
